// ===== design/mgo_pkg.sv =====
// shared constants, state and control types for the median gain/offset block
package mgo_pkg;

  // field and register widths
  localparam int PIX_W      = 8;
  localparam int CON_W      = 10;
  localparam int BRI_W      = 9;
  localparam int DIM_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // default frame limits
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int MIN_DIM        = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CONTRAST   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT     = 2'd3;

  // register reset values
  localparam logic [CON_W-1:0] CONTRAST_RST = 10'd50;
  localparam logic [BRI_W-1:0] BRIGHT_RST   = 9'd0;
  localparam logic [DIM_W-1:0] DIM_RST      = 11'd512;

  // opcodes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // gain/offset arithmetic: (x*c + 50*b) / 50 rounded half to even, via biased reciprocal multiply
  localparam int DIV      = 50;
  localparam int DIV_BIAS = 3000;
  localparam int NUM_OFS  = DIV * DIV_BIAS;
  localparam int ACC_W    = 20;
  localparam int NUM_W    = 19;
  localparam int RECIP_SH = 24;
  localparam int RECIP    = (1 << RECIP_SH) / DIV;
  localparam int PROD_W   = 2 * NUM_W;
  localparam int Q_W      = 13;
  localparam int REM_W    = 6;
  localparam int HALF_DIV = DIV / 2;
  localparam int PIX_MAX  = 255;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_IA1,
    ST_IA2,
    ST_IA3,
    ST_SORT,
    ST_MED,
    ST_FL,
    ST_OA1,
    ST_OA2,
    ST_OA3,
    ST_OUT
  } state_e;

  // control of the word in flight
  typedef struct packed {
    logic op;
    logic emit;
    logic shadow;
    logic border;
    logic last_col;
    logic eor;
    logic eof;
  } item_ctl_t;

endpackage

// ===== design/mgo_if.sv =====
// valid/ready channel interfaces for input and result words
interface mgo_in_if import mgo_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             opcode;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, opcode, pixel_in, input ready);
  modport sink   (input valid, opcode, pixel_in, output ready);
endinterface

interface mgo_out_if import mgo_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             end_of_row;
  logic             end_of_frame;

  modport source (output valid, pixel_out, end_of_row, end_of_frame, input ready);
  modport sink   (input valid, pixel_out, end_of_row, end_of_frame, output ready);
endinterface

// ===== design/median3x3_with_gain_offset_unit.sv =====
// 3x3 median filter with gain/offset adjustment before and after the median
//
// raster-order 8-bit pixels come in on in_i; each is adjusted to
// clamp(round_half_even(x*contrast/50 + brightness), 0, 255), pushed through two
// line stores and a 3x3 window, and the median of the window (or the adjusted
// pixel itself on the outer rows and columns) is adjusted once more and sent
// out on out_o, width+1 words behind the input. after the last pixel of a
// frame, width+1 flush words (opcode 1) drain the tail; end_of_row and
// end_of_frame mark the last pixel of a row and of the frame. writing the
// width or height register restarts framing. configuration must be written
// only while the block is idle; the block itself does not enforce this. one
// word is worked on at a time: each pixel passes through one shared
// three-stage gain/offset pipeline, and each result passes through it once
// more after the registered read of the line stores and, where the median
// is taken, the two median stages. a finished result sits in an output
// register, so the next word is taken while it waits; only a second result
// can stall on a busy output. the line stores are not cleared after reset:
// an entry read before it is written in a frame feeds no result.
module median3x3_with_gain_offset_unit import mgo_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  mgo_in_if.sink                in_i,
  mgo_out_if.source             out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int CW = $clog2(MAX_WIDTH);       // column / line store address
  localparam int WW = $clog2(MAX_WIDTH + 2);   // width, pending count (up to width+1)
  localparam int RW = $clog2(MAX_HEIGHT + 1);  // row count, height

  // configuration registers
  logic signed [CON_W-1:0] contrast_q;
  logic signed [BRI_W-1:0] bright_q;
  logic [DIM_W-1:0]        width_q;
  logic [DIM_W-1:0]        height_q;
  logic                    dim_wr;

  // framing state
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [WW-1:0] pend_q, pend_d;
  logic [WW-1:0] w_eff;
  logic [RW-1:0] h_eff;

  // sequencer
  state_e    state_q, state_d;
  item_ctl_t it_q, it_d;
  logic [CW-1:0] it_col_q;

  // accept-time decode
  logic          in_fire;
  logic          restart;
  logic [CW-1:0] cur_c;
  logic [RW-1:0] cur_r;
  logic [WW-1:0] cur_p;
  logic [WW-1:0] c_inc;
  logic          col_wrap;
  logic          emit_px;
  logic          fl_live;
  logic          fl_upper;
  logic [WW-1:0] fl_col;
  logic [CW-1:0] rd_addr;

  // line stores
  logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
  logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
  logic [PIX_W-1:0] rd_up_q;
  logic [PIX_W-1:0] rd_mid_q;
  logic [PIX_W-1:0] shadow_q;   // copy of the upper store entry at the last column

  // window and median
  logic [PIX_W-1:0] win_q [9];
  logic [PIX_W-1:0] lo_q [3];
  logic [PIX_W-1:0] mi_q [3];
  logic [PIX_W-1:0] hi_q [3];
  logic [PIX_W-1:0] val_q;
  logic [PIX_W-1:0] med_val;

  // sequencer outputs
  logic mem_we;
  logic win_shift;
  logic val_from_ia3;
  logic val_from_fl;
  logic val_from_med;
  logic out_load;
  logic a3_en;

  // gain/offset pipeline
  logic [PIX_W-1:0]        adj_x;
  logic signed [ACC_W-1:0] acc1;
  logic [NUM_W-1:0]        a1_q;
  logic [PROD_W-1:0]       a2_prod_q;
  logic [NUM_W-1:0]        a2_n_q;
  logic [Q_W-1:0]          q0;
  logic [NUM_W-1:0]        r0;
  logic                    rcorr;
  logic [Q_W-1:0]          q1;
  logic [REM_W-1:0]        rr;
  logic                    rnd;
  logic [Q_W-1:0]          q2;
  logic [PIX_W-1:0]        adj_res;
  logic [PIX_W-1:0]        a3_q;

  // output register
  logic             out_valid_q;
  logic [PIX_W-1:0] out_pix_q;
  logic             out_eor_q;
  logic             out_eof_q;

  function automatic logic [PIX_W-1:0] min2(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [PIX_W-1:0] max2(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic [PIX_W-1:0] med3(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b,
                                            input logic [PIX_W-1:0] c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  // ---------------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------------
  assign dim_wr = cfg_we_i && ((cfg_idx_i == CFG_WIDTH) || (cfg_idx_i == CFG_HEIGHT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      contrast_q <= CONTRAST_RST;
      bright_q   <= BRIGHT_RST;
      width_q    <= DIM_RST;
      height_q   <= DIM_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CONTRAST:   contrast_q <= cfg_wdata_i[CON_W-1:0];
        CFG_BRIGHTNESS: bright_q   <= cfg_wdata_i[BRI_W-1:0];
        CFG_WIDTH:      width_q    <= cfg_wdata_i[DIM_W-1:0];
        CFG_HEIGHT:     height_q   <= cfg_wdata_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // dimensions in use, clamped to 3..max
  always_comb begin
    if (width_q < DIM_W'(MIN_DIM)) begin
      w_eff = WW'(MIN_DIM);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_q);
    end
    if (height_q < DIM_W'(MIN_DIM)) begin
      h_eff = RW'(MIN_DIM);
    end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
      h_eff = RW'(MAX_HEIGHT);
    end else begin
      h_eff = RW'(height_q);
    end
  end

  // ---------------------------------------------------------------------------
  // accept-time decode of the incoming word
  // ---------------------------------------------------------------------------
  assign in_fire = in_i.valid && in_i.ready;

  always_comb begin
    // a pixel after a complete frame (or past the row) starts a new frame
    restart  = (row_q >= h_eff) || (WW'(col_q) >= w_eff);
    cur_c    = restart ? '0 : col_q;
    cur_r    = restart ? '0 : row_q;
    cur_p    = restart ? '0 : pend_q;
    c_inc    = WW'(cur_c) + WW'(1);
    col_wrap = (c_inc >= w_eff);
    emit_px  = (cur_p >= (w_eff + WW'(1)));

    // flush drains only a finished frame
    fl_live  = (row_q >= h_eff) && (pend_q != '0);
    fl_upper = (pend_q > w_eff);
    fl_col   = w_eff - pend_q;

    rd_addr  = (in_i.opcode == OP_PIXEL) ? cur_c : fl_col[CW-1:0];

    it_d.op       = in_i.opcode;
    it_d.emit     = (in_i.opcode == OP_PIXEL) ? emit_px : fl_live;
    // first column result is the last pixel of the row two above: held in shadow
    it_d.shadow   = (in_i.opcode == OP_PIXEL) ? (cur_c == '0) : fl_upper;
    it_d.border   = (cur_r == RW'(1)) || (cur_c == CW'(1));
    it_d.last_col = (c_inc == w_eff);
    it_d.eor      = (in_i.opcode == OP_PIXEL) ? (cur_c == '0)
                                              : (fl_upper || (pend_q == WW'(1)));
    it_d.eof      = (in_i.opcode == OP_FLUSH) && (pend_q == WW'(1));
  end

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    pend_d = pend_q;
    if (dim_wr) begin
      col_d  = '0;
      row_d  = '0;
      pend_d = '0;
    end else if (in_fire) begin
      if (in_i.opcode == OP_PIXEL) begin
        col_d  = col_wrap ? '0 : c_inc[CW-1:0];
        row_d  = col_wrap ? (cur_r + RW'(1)) : cur_r;
        pend_d = emit_px ? cur_p : (cur_p + WW'(1));
      end else if (fl_live) begin
        pend_d = pend_q - WW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      pend_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      it_q <= '0;
    end else if (in_fire) begin
      it_q <= it_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      it_col_q <= cur_c;
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_i.opcode == OP_PIXEL) begin
            state_d = ST_IA1;
          end else if (fl_live) begin
            state_d = ST_FL;
          end
        end
      end
      ST_IA1:  state_d = ST_IA2;
      ST_IA2:  state_d = ST_IA3;
      ST_IA3: begin
        if (!it_q.emit) begin
          state_d = ST_IDLE;
        end else if (it_q.shadow) begin
          state_d = ST_OA1;
        end else begin
          state_d = ST_SORT;
        end
      end
      ST_SORT: state_d = ST_MED;
      ST_MED:  state_d = ST_OA1;
      ST_FL:   state_d = ST_OA1;
      ST_OA1:  state_d = ST_OA2;
      ST_OA2:  state_d = ST_OA3;
      ST_OA3:  state_d = ST_OUT;
      ST_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready   = 1'b0;
    mem_we       = 1'b0;
    win_shift    = 1'b0;
    val_from_ia3 = 1'b0;
    val_from_fl  = 1'b0;
    val_from_med = 1'b0;
    out_load     = 1'b0;
    a3_en        = 1'b1;
    case (state_q)
      ST_IDLE: in_i.ready = 1'b1;
      ST_IA3: begin
        mem_we       = 1'b1;
        win_shift    = 1'b1;
        val_from_ia3 = it_q.emit && it_q.shadow;
      end
      ST_MED:  val_from_med = 1'b1;
      ST_FL:   val_from_fl  = 1'b1;
      ST_OUT: begin
        a3_en    = 1'b0;
        out_load = !out_valid_q || out_o.ready;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------------------
  // line stores: registered read at accept, write back of the column
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rd_up_q  <= upper_mem[rd_addr];
      rd_mid_q <= middle_mem[rd_addr];
    end
    if (mem_we) begin
      upper_mem[it_col_q]  <= rd_mid_q;
      middle_mem[it_col_q] <= a3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we && it_q.last_col) begin
      shadow_q <= rd_mid_q;
    end
  end

  // ---------------------------------------------------------------------------
  // 3x3 window, column sort, median
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else if (win_shift) begin
      for (int k = 0; k < 3; k++) begin
        win_q[k*3]   <= win_q[k*3+1];
        win_q[k*3+1] <= win_q[k*3+2];
      end
      win_q[2] <= rd_up_q;
      win_q[5] <= rd_mid_q;
      win_q[8] <= a3_q;
    end
  end

  // sort each column of three
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      lo_q[j] <= min2(min2(win_q[j], win_q[3+j]), win_q[6+j]);
      mi_q[j] <= med3(win_q[j], win_q[3+j], win_q[6+j]);
      hi_q[j] <= max2(max2(win_q[j], win_q[3+j]), win_q[6+j]);
    end
  end

  // median of nine = med3(max of lows, med of mids, min of highs)
  assign med_val = med3(max2(max2(lo_q[0], lo_q[1]), lo_q[2]),
                        med3(mi_q[0], mi_q[1], mi_q[2]),
                        min2(min2(hi_q[0], hi_q[1]), hi_q[2]));

  always_ff @(posedge clk_i) begin
    if (val_from_ia3) begin
      val_q <= shadow_q;
    end else if (val_from_fl) begin
      val_q <= it_q.shadow ? shadow_q : rd_mid_q;
    end else if (val_from_med) begin
      val_q <= it_q.border ? win_q[4] : med_val;
    end
  end

  // ---------------------------------------------------------------------------
  // gain/offset pipeline, shared by both adjustments
  // stage 1: x*c + 50*b, biased positive
  // stage 2: reciprocal multiply for the quotient by 50
  // stage 3: one correction step, round half to even, clamp
  // ---------------------------------------------------------------------------
  assign adj_x = (state_q == ST_IDLE) ? in_i.pixel_in : val_q;

  assign acc1 = ACC_W'(signed'({1'b0, adj_x})) * ACC_W'(contrast_q)
              + ACC_W'(bright_q) * ACC_W'(DIV)
              + ACC_W'(NUM_OFS);

  always_ff @(posedge clk_i) begin
    a1_q      <= acc1[NUM_W-1:0];
    a2_prod_q <= PROD_W'(a1_q) * PROD_W'(RECIP);
    a2_n_q    <= a1_q;
  end

  always_comb begin
    q0    = a2_prod_q[RECIP_SH +: Q_W];
    r0    = a2_n_q - NUM_W'(q0) * NUM_W'(DIV);
    rcorr = (r0 >= NUM_W'(DIV));
    q1    = rcorr ? (q0 + Q_W'(1)) : q0;
    rr    = rcorr ? REM_W'(r0 - NUM_W'(DIV)) : REM_W'(r0);
    rnd   = (rr > REM_W'(HALF_DIV)) || ((rr == REM_W'(HALF_DIV)) && q1[0]);
    q2    = q1 + Q_W'(rnd);
    if (q2 < Q_W'(DIV_BIAS)) begin
      adj_res = '0;
    end else if (q2 > Q_W'(DIV_BIAS + PIX_MAX)) begin
      adj_res = PIX_W'(PIX_MAX);
    end else begin
      adj_res = PIX_W'(q2 - Q_W'(DIV_BIAS));
    end
  end

  always_ff @(posedge clk_i) begin
    if (a3_en) begin
      a3_q <= adj_res;
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_pix_q <= a3_q;
      out_eor_q <= it_q.eor;
      out_eof_q <= it_q.eof;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.pixel_out    = out_pix_q;
  assign out_o.end_of_row   = out_eor_q;
  assign out_o.end_of_frame = out_eof_q;

`ifndef SYNTH
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= (w_eff + WW'(1)))
    else $error("pending count above width+1");

  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    WW'(col_q) < w_eff)
    else $error("column count outside the row");

  a_pixel_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_i.opcode == OP_PIXEL)) |=> (state_q == ST_IA1))
    else $error("accepted pixel did not start the input adjustment");

  a_eof_eor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.end_of_frame) |-> out_o.end_of_row)
    else $error("end of frame without end of row");
`endif

endmodule
